FILE: design/dop_pkg.sv
// Package with shared widths, request codes and chain command types for the dual-order queue.
`timescale 1ns / 1ps

package dop_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int REQ_W  = 3;
    localparam int PRI_W  = 8;
    localparam int HR_W   = 5;
    localparam int MN_W   = 6;
    localparam int SC_W   = 6;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int TKEY_W = 17;
    localparam int IN_W   = 72;
    localparam int OUT_W  = 48;

    localparam logic [TKEY_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [TKEY_W-1:0] SEC_PER_MIN  = 17'd60;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD, REQ_POP_PRI, REQ_POP_ARR, REQ_PEEK_PRI,
        REQ_PEEK_ARR, REQ_CHG_PRI, REQ_CHG_ARR, REQ_NOP
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK, ST_EMPTY, ST_FULL, ST_NOT_FOUND
    } t_status;

    typedef enum logic [1:0] {
        CH_IDLE, CH_INSERT, CH_REM_SLOT, CH_REM_KEY
    } t_chop;

    // Command broadcast to every cell of a chain.
    typedef struct packed {
        t_chop               op;
        logic [TKEY_W-1:0]   key;
    } t_chain_cmd;

    // Arrival time in seconds from the raw hour, minute and second fields.
    function automatic logic [TKEY_W-1:0] arrival_key(
        input logic [HR_W-1:0] h, input logic [MN_W-1:0] m, input logic [SC_W-1:0] s);
        arrival_key = TKEY_W'(h) * SEC_PER_HOUR + TKEY_W'(m) * SEC_PER_MIN + TKEY_W'(s);
    endfunction

endpackage

FILE: design/dop_cell.sv
// One cell of a sorted chain: holds a key and a slot number and trades them with its neighbors.
`timescale 1ns / 1ps

module dop_cell import dop_pkg::*; #(
    parameter int   KEY_W   = 8,
    parameter int   SLOT_W  = 4,
    parameter logic DESCEND = 1'b1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chain_cmd        i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_left_valid,
    input  logic [KEY_W-1:0]  i_left_key,
    input  logic [SLOT_W-1:0] i_left_slot,
    input  logic              i_left_stay,
    input  logic              i_right_valid,
    input  logic [KEY_W-1:0]  i_right_key,
    input  logic [SLOT_W-1:0] i_right_slot,
    input  logic              i_seen,
    output logic              o_valid,
    output logic [KEY_W-1:0]  o_key,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_stay,
    output logic              o_match,
    output logic              o_seen
);

    logic              r_valid, n_valid;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              w_ahead;
    logic [KEY_W-1:0]  w_cmd_key;

    assign w_cmd_key = i_cmd.key[KEY_W-1:0];

    // An entry stays ahead of a new key only when it strictly precedes it.
    assign w_ahead = DESCEND ? (r_key > w_cmd_key) : (r_key < w_cmd_key);
    assign o_stay  = r_valid && w_ahead;
    assign o_match = r_valid && ((i_cmd.op == CH_REM_SLOT) ? (r_slot == i_slot)
                                                           : (r_key == w_cmd_key));
    assign o_seen  = i_seen || o_match;

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_slot  = r_slot;

    // Next contents: keep, take the new entry, take the left one, or take the right one.
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_slot  = r_slot;
        unique case (i_cmd.op)
            CH_INSERT: begin
                if (!o_stay) begin
                    if (i_left_stay) begin
                        n_valid = 1'b1;
                        n_key   = w_cmd_key;
                        n_slot  = i_slot;
                    end else begin
                        n_valid = i_left_valid;
                        n_key   = i_left_key;
                        n_slot  = i_left_slot;
                    end
                end
            end
            CH_REM_SLOT, CH_REM_KEY: begin
                if (o_seen) begin
                    n_valid = i_right_valid;
                    n_key   = i_right_key;
                    n_slot  = i_right_slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_slot <= n_slot;
    end

endmodule

FILE: design/dop_chain.sv
// A row of cells that keeps slot numbers sorted by one key.
`timescale 1ns / 1ps

module dop_chain import dop_pkg::*; #(
    parameter int   CAPACITY = CAPACITY_DEF,
    parameter int   KEY_W    = 8,
    parameter int   SLOT_W   = 4,
    parameter logic DESCEND  = 1'b1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chain_cmd        i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_head_valid,
    output logic [SLOT_W-1:0] o_head_slot,
    output logic              o_found,
    output logic [SLOT_W-1:0] o_found_slot
);

    logic              w_valid [CAPACITY+1];
    logic [KEY_W-1:0]  w_key   [CAPACITY+1];
    logic [SLOT_W-1:0] w_slot  [CAPACITY+1];
    logic              w_stay  [CAPACITY+1];
    logic              w_seen  [CAPACITY+1];
    logic              w_match [CAPACITY];

    // Edge ties: left of the head always lets a new entry in, right of the tail is empty.
    assign w_stay[0]         = 1'b1;
    assign w_seen[0]         = 1'b0;
    assign w_valid[CAPACITY] = 1'b0;
    assign w_key[CAPACITY]   = '0;
    assign w_slot[CAPACITY]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic              w_lv;
        logic [KEY_W-1:0]  w_lk;
        logic [SLOT_W-1:0] w_ls;
        if (g == 0) begin : g_head
            assign w_lv = 1'b0;
            assign w_lk = '0;
            assign w_ls = '0;
        end else begin : g_body
            assign w_lv = w_valid[g-1];
            assign w_lk = w_key[g-1];
            assign w_ls = w_slot[g-1];
        end
        dop_cell #(.KEY_W(KEY_W), .SLOT_W(SLOT_W), .DESCEND(DESCEND)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_slot       (i_slot),
            .i_left_valid (w_lv),
            .i_left_key   (w_lk),
            .i_left_slot  (w_ls),
            .i_left_stay  (w_stay[g]),
            .i_right_valid(w_valid[g+1]),
            .i_right_key  (w_key[g+1]),
            .i_right_slot (w_slot[g+1]),
            .i_seen       (w_seen[g]),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_slot       (w_slot[g]),
            .o_stay       (w_stay[g+1]),
            .o_match      (w_match[g]),
            .o_seen       (w_seen[g+1])
        );
    end

    assign o_head_valid = w_valid[0];
    assign o_head_slot  = w_slot[0];
    assign o_found      = w_seen[CAPACITY];

    // Slot of the first matching cell.
    always_comb begin
        o_found_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i] && !w_seen[i]) begin
                o_found_slot = o_found_slot | w_slot[i];
            end
        end
    end

endmodule

FILE: design/dual_order_process_queue.sv
// Top level of the dual-order process queue: request control, entry store and two sorted chains.
//
// Channel   Dir  Bits  Contents
// s_axis    in   72    one request beat
// m_axis    out  48    one result beat per request
//
// A request passes through accept, chain update and result; a change request that finds its
// entry adds a reinsert step: the entry is unlinked in the chain update, reinserted in the next.
// The chains shift one place per cycle, so every request is handled one at a time.
// Reset empties both chains and the slot map at once; entry payloads need no clearing.
// A stalled result holds the block until the result beat is taken.
`timescale 1ns / 1ps

module dual_order_process_queue import dop_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // tdata from bit 0: req_type, priority_req, hour, minute, second, new_priority,
    // new_hour, new_minute, new_second, tag, zero pad
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // tdata from bit 0: status, out_priority, out_hour, out_minute, out_second,
    // out_tag, occupancy
    output logic [OUT_W-1:0] o_m_tdata
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_INS, S_OUT} t_state;

    t_state r_state;

    // Captured request.
    t_req             r_req;
    logic [PRI_W-1:0] r_pri, r_npri;
    logic [HR_W-1:0]  r_hr, r_nhr;
    logic [MN_W-1:0]  r_mn, r_nmn;
    logic [SC_W-1:0]  r_sc, r_nsc;
    logic [TAG_W-1:0] r_tag;

    // Entry store and its slot map.
    logic [PRI_W-1:0] r_e_pri [CAPACITY];
    logic [HR_W-1:0]  r_e_hr  [CAPACITY];
    logic [MN_W-1:0]  r_e_mn  [CAPACITY];
    logic [SC_W-1:0]  r_e_sc  [CAPACITY];
    logic [TAG_W-1:0] r_e_tag [CAPACITY];
    logic             r_used  [CAPACITY];

    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_slot;

    // Result fields.
    t_status          r_o_stat;
    logic [PRI_W-1:0] r_o_pri;
    logic [HR_W-1:0]  r_o_hr;
    logic [MN_W-1:0]  r_o_mn;
    logic [SC_W-1:0]  r_o_sc;
    logic [TAG_W-1:0] r_o_tag;

    logic              w_full, w_empty, w_free_any;
    logic [SLOT_W-1:0] w_free, w_cmd_slot, w_rd_slot;
    t_chain_cmd        w_pcmd, w_tcmd;
    logic              w_p_hv, w_t_hv, w_p_found, w_t_found;
    logic [SLOT_W-1:0] w_p_hs, w_t_hs, w_p_fs, w_t_fs;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {OCC_W'(r_count), r_o_tag, r_o_sc, r_o_mn, r_o_hr, r_o_pri, r_o_stat};

    // Lowest free slot.
    always_comb begin
        w_free     = '0;
        w_free_any = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!w_free_any && !r_used[i]) begin
                w_free     = SLOT_W'(i);
                w_free_any = 1'b1;
            end
        end
    end

    assign w_rd_slot = (r_req == REQ_POP_ARR || r_req == REQ_PEEK_ARR) ? w_t_hs : w_p_hs;

    // Chain commands for the current step.
    always_comb begin
        w_pcmd     = '{op: CH_IDLE, key: '0};
        w_tcmd     = '{op: CH_IDLE, key: '0};
        w_cmd_slot = r_slot;
        if (r_state == S_RUN) begin
            unique case (r_req)
                REQ_ADD: begin
                    if (!w_full) begin
                        w_pcmd     = '{op: CH_INSERT, key: TKEY_W'(r_pri)};
                        w_tcmd     = '{op: CH_INSERT, key: arrival_key(r_hr, r_mn, r_sc)};
                        w_cmd_slot = w_free;
                    end
                end
                REQ_POP_PRI, REQ_POP_ARR: begin
                    if (!w_empty) begin
                        w_pcmd     = '{op: CH_REM_SLOT, key: '0};
                        w_tcmd     = '{op: CH_REM_SLOT, key: '0};
                        w_cmd_slot = w_rd_slot;
                    end
                end
                REQ_CHG_PRI: w_pcmd = '{op: CH_REM_KEY, key: TKEY_W'(r_pri)};
                REQ_CHG_ARR: w_tcmd = '{op: CH_REM_KEY, key: arrival_key(r_hr, r_mn, r_sc)};
                default: begin
                end
            endcase
        end else if (r_state == S_INS) begin
            if (r_req == REQ_CHG_PRI) begin
                w_pcmd = '{op: CH_INSERT, key: TKEY_W'(r_npri)};
            end else begin
                w_tcmd = '{op: CH_INSERT, key: arrival_key(r_nhr, r_nmn, r_nsc)};
            end
        end
    end

    dop_chain #(.CAPACITY(CAPACITY), .KEY_W(PRI_W), .SLOT_W(SLOT_W), .DESCEND(1'b1)) u_pchain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pcmd),
        .i_slot      (w_cmd_slot),
        .o_head_valid(w_p_hv),
        .o_head_slot (w_p_hs),
        .o_found     (w_p_found),
        .o_found_slot(w_p_fs)
    );

    dop_chain #(.CAPACITY(CAPACITY), .KEY_W(TKEY_W), .SLOT_W(SLOT_W), .DESCEND(1'b0)) u_tchain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_tcmd),
        .i_slot      (w_cmd_slot),
        .o_head_valid(w_t_hv),
        .o_head_slot (w_t_hs),
        .o_found     (w_t_found),
        .o_found_slot(w_t_fs)
    );

    // Request capture on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_req  <= t_req'(i_s_tdata[2:0]);
            r_pri  <= i_s_tdata[10:3];
            r_hr   <= i_s_tdata[15:11];
            r_mn   <= i_s_tdata[21:16];
            r_sc   <= i_s_tdata[27:22];
            r_npri <= i_s_tdata[35:28];
            r_nhr  <= i_s_tdata[40:36];
            r_nmn  <= i_s_tdata[46:41];
            r_nsc  <= i_s_tdata[52:47];
            r_tag  <= i_s_tdata[68:53];
        end
    end

    // Entry store writes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && r_req == REQ_ADD && !w_full) begin
            r_e_pri[w_free] <= r_pri;
            r_e_hr[w_free]  <= r_hr;
            r_e_mn[w_free]  <= r_mn;
            r_e_sc[w_free]  <= r_sc;
            r_e_tag[w_free] <= r_tag;
        end else if (r_state == S_INS && r_req == REQ_CHG_PRI) begin
            r_e_pri[r_slot] <= r_npri;
        end else if (r_state == S_INS) begin
            r_e_hr[r_slot] <= r_nhr;
            r_e_mn[r_slot] <= r_nmn;
            r_e_sc[r_slot] <= r_nsc;
        end
    end

    // Request sequencer, slot map, count and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_slot   <= '0;
            r_o_stat <= ST_OK;
            r_o_pri  <= '0;
            r_o_hr   <= '0;
            r_o_mn   <= '0;
            r_o_sc   <= '0;
            r_o_tag  <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_state  <= S_OUT;
                    r_o_stat <= ST_OK;
                    r_o_pri  <= '0;
                    r_o_hr   <= '0;
                    r_o_mn   <= '0;
                    r_o_sc   <= '0;
                    r_o_tag  <= '0;
                    unique case (r_req)
                        REQ_ADD: begin
                            if (w_full) begin
                                r_o_stat <= ST_FULL;
                            end else begin
                                r_used[w_free] <= 1'b1;
                                r_count        <= r_count + 1'b1;
                            end
                        end
                        REQ_POP_PRI, REQ_POP_ARR, REQ_PEEK_PRI, REQ_PEEK_ARR: begin
                            if (w_empty) begin
                                r_o_stat <= ST_EMPTY;
                            end else begin
                                r_o_pri <= r_e_pri[w_rd_slot];
                                r_o_hr  <= r_e_hr[w_rd_slot];
                                r_o_mn  <= r_e_mn[w_rd_slot];
                                r_o_sc  <= r_e_sc[w_rd_slot];
                                r_o_tag <= r_e_tag[w_rd_slot];
                                if (r_req == REQ_POP_PRI || r_req == REQ_POP_ARR) begin
                                    r_used[w_rd_slot] <= 1'b0;
                                    r_count           <= r_count - 1'b1;
                                end
                            end
                        end
                        REQ_CHG_PRI: begin
                            if (w_p_found) begin
                                r_slot  <= w_p_fs;
                                r_state <= S_INS;
                            end else begin
                                r_o_stat <= ST_NOT_FOUND;
                            end
                        end
                        REQ_CHG_ARR: begin
                            if (w_t_found) begin
                                r_slot  <= w_t_fs;
                                r_state <= S_INS;
                            end else begin
                                r_o_stat <= ST_NOT_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_INS: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Both chains hold an entry at their heads exactly when the queue is not empty,
    // except while a changed entry is unlinked from one chain.
    a_heads_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INS) |-> ((w_p_hv == w_t_hv) && (w_p_hv == !w_empty)))
        else $error("chain heads disagree with entry count");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A dropped add is only reported when the queue is full.
    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_stat == ST_FULL) |-> w_full)
        else $error("full status while not full");

    // A priority pop from a non-empty queue lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_req == REQ_POP_PRI && !w_empty)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not lower the count");
`endif

endmodule

FILE: sim/tb.sv
// Testbench for the dual-order process queue: random requests checked against a behavioral queue.
`timescale 1ns / 1ps

// Holds the expected queue contents and the results still owed by the block.
class queue_scoreboard;
    typedef struct {
        logic [7:0]  pri;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [15:0] tag;
    } t_entry;

    t_entry          ent[16];
    bit              used[16];
    int              pri_order[$];
    int              arr_order[$];
    logic [47:0]     owed[$];
    int              mismatches;
    int              checked;

    function new();
        mismatches = 0;
        checked = 0;
        foreach (used[i]) used[i] = 0;
    endfunction

    function int arrival_secs(logic [4:0] h, logic [5:0] m, logic [5:0] s);
        return int'(h) * 3600 + int'(m) * 60 + int'(s);
    endfunction

    function int slot_secs(int slot);
        return arrival_secs(ent[slot].hr, ent[slot].mn, ent[slot].sc);
    endfunction

    // Newest key goes ahead of equal keys in both orders.
    function void link_pri(int slot);
        int pos;
        pos = 0;
        while (pos < pri_order.size() && ent[pri_order[pos]].pri > ent[slot].pri) pos++;
        pri_order.insert(pos, slot);
    endfunction

    function void link_arr(int slot);
        int pos;
        pos = 0;
        while (pos < arr_order.size() && slot_secs(arr_order[pos]) < slot_secs(slot)) pos++;
        arr_order.insert(pos, slot);
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(logic [71:0] d);
        logic [2:0] req;
        logic [1:0] st;
        int hit, slot, pos;
        logic [47:0] r;
        req = d[2:0];
        st = dop_pkg::ST_OK;
        hit = -1;
        case (req)
            dop_pkg::REQ_ADD: begin
                if (pri_order.size() >= 16) begin
                    st = dop_pkg::ST_FULL;
                end else begin
                    slot = 0;
                    while (used[slot]) slot++;
                    used[slot] = 1;
                    ent[slot].pri = d[10:3];
                    ent[slot].hr = d[15:11];
                    ent[slot].mn = d[21:16];
                    ent[slot].sc = d[27:22];
                    ent[slot].tag = d[68:53];
                    link_pri(slot);
                    link_arr(slot);
                end
            end
            dop_pkg::REQ_POP_PRI, dop_pkg::REQ_POP_ARR,
            dop_pkg::REQ_PEEK_PRI, dop_pkg::REQ_PEEK_ARR: begin
                if (pri_order.size() == 0) begin
                    st = dop_pkg::ST_EMPTY;
                end else begin
                    hit = (req == dop_pkg::REQ_POP_PRI || req == dop_pkg::REQ_PEEK_PRI)
                        ? pri_order[0] : arr_order[0];
                    if (req == dop_pkg::REQ_POP_PRI || req == dop_pkg::REQ_POP_ARR) begin
                        foreach (pri_order[i]) if (pri_order[i] == hit) pos = i;
                        pri_order.delete(pos);
                        foreach (arr_order[i]) if (arr_order[i] == hit) pos = i;
                        arr_order.delete(pos);
                        used[hit] = 0;
                    end
                end
            end
            dop_pkg::REQ_CHG_PRI: begin
                pos = -1;
                foreach (pri_order[i])
                    if (pos < 0 && ent[pri_order[i]].pri == d[10:3]) pos = i;
                if (pos < 0) begin
                    st = dop_pkg::ST_NOT_FOUND;
                end else begin
                    slot = pri_order[pos];
                    pri_order.delete(pos);
                    ent[slot].pri = d[35:28];
                    link_pri(slot);
                end
            end
            dop_pkg::REQ_CHG_ARR: begin
                pos = -1;
                foreach (arr_order[i])
                    if (pos < 0 && slot_secs(arr_order[i]) ==
                        arrival_secs(d[15:11], d[21:16], d[27:22])) pos = i;
                if (pos < 0) begin
                    st = dop_pkg::ST_NOT_FOUND;
                end else begin
                    slot = arr_order[pos];
                    arr_order.delete(pos);
                    ent[slot].hr = d[40:36];
                    ent[slot].mn = d[46:41];
                    ent[slot].sc = d[52:47];
                    link_arr(slot);
                end
            end
            default: ;
        endcase
        r = '0;
        r[1:0] = st;
        if (hit >= 0)
            r[42:2] = {ent[hit].tag, ent[hit].sc, ent[hit].mn, ent[hit].hr, ent[hit].pri};
        r[47:43] = 5'(pri_order.size());
        owed.push_back(r);
    endfunction

    function void check_result(logic [47:0] got);
        logic [47:0] exp_r;
        checked++;
        if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
        end
        exp_r = owed.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: expected st=%0d pri=%0d h=%0d m=%0d s=%0d tag=%0h occ=%0d",
                    checked, exp_r[1:0], exp_r[9:2], exp_r[14:10], exp_r[20:15], exp_r[26:21],
                    exp_r[42:27], exp_r[47:43]);
            if (mismatches <= 10)
                $display("           got      st=%0d pri=%0d h=%0d m=%0d s=%0d tag=%0h occ=%0d",
                    got[1:0], got[9:2], got[14:10], got[20:15], got[26:21],
                    got[42:27], got[47:43]);
        end
    endfunction
endclass

module tb;
    import dop_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_s_tvalid = 0;
    logic              s_tready;
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 0;
    logic [OUT_W-1:0]  o_m_tdata;

    queue_scoreboard   board;
    int                idle_cycles = 0;
    int                sent = 0;
    bit                quiet = 0;
    bit                hold_rx = 0;
    bit                timed_out = 0;
    int                used_pri[$];
    int                used_arr[$];

    always #1 i_clk = ~i_clk;

    dual_order_process_queue uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    // Receiver: random stalls, a forced long hold, then steady ready.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
        if ((s_tready && i_s_tvalid) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                i_m_tready <= 0;
                repeat (200) @(posedge i_clk);
                hold_rx = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
                i_m_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    // Keys are often reused so that changes find a match.
    function logic [IN_W-1:0] make_req(logic [2:0] req);
        logic [IN_W-1:0] d;
        logic [7:0] p;
        logic [4:0] h;
        logic [5:0] m, s;
        int k;
        d = '0;
        p = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) p = 8'($urandom_range(0, 3));
        h = 5'($urandom_range(0, 23));
        m = 6'($urandom_range(0, 59));
        s = 6'($urandom_range(0, 59));
        if ($urandom_range(0, 15) == 0) begin
            h = 5'($urandom);
            m = 6'($urandom);
            s = 6'($urandom);
        end
        if (req == REQ_CHG_PRI && used_pri.size() > 0 && $urandom_range(0, 4) != 0)
            p = 8'(used_pri[$urandom_range(0, used_pri.size() - 1)]);
        if (req == REQ_CHG_ARR && used_arr.size() > 0 && $urandom_range(0, 4) != 0) begin
            k = used_arr[$urandom_range(0, used_arr.size() - 1)];
            {h, m, s} = 17'(k);
        end
        if (req == REQ_ADD) begin
            used_pri.push_back(p);
            used_arr.push_back({h, m, s});
        end
        d[2:0] = req;
        d[10:3] = p;
        d[15:11] = h;
        d[21:16] = m;
        d[27:22] = s;
        d[35:28] = 8'($urandom);
        d[40:36] = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
        d[46:41] = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        d[52:47] = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        d[68:53] = 16'($urandom);
        if (req == REQ_CHG_PRI) used_pri.push_back(d[35:28]);
        if (req == REQ_CHG_ARR) used_arr.push_back({d[40:36], d[46:41], d[52:47]});
        return d;
    endfunction

    task automatic send_req(logic [IN_W-1:0] d);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_request(d);
        sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic send_plain(logic [2:0] req, logic [7:0] p, logic [16:0] hms,
                              logic [7:0] np, logic [16:0] nhms, logic [15:0] tg);
        logic [IN_W-1:0] d;
        d = '0;
        d[2:0] = req;
        d[10:3] = p;
        d[27:11] = {hms[5:0], hms[11:6], hms[16:12]};
        d[35:28] = np;
        d[52:36] = {nhms[5:0], nhms[11:6], nhms[16:12]};
        d[68:53] = tg;
        send_req(d);
    endtask

    // Watchdog on cycles with no beat moving.
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_cycles > 5000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] req;
        int mode;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty cases, extremes, ties, full queue, unused code.
        send_plain(REQ_POP_PRI, 0, 0, 0, 0, 0);
        send_plain(REQ_PEEK_ARR, 0, 0, 0, 0, 0);
        send_plain(REQ_CHG_PRI, 5, 0, 9, 0, 0);
        send_plain(REQ_CHG_ARR, 0, 0, 0, 0, 0);
        send_plain(REQ_ADD, 8'hFF, {5'd23, 6'd59, 6'd59}, 0, 0, 16'hFFFF);
        send_plain(REQ_ADD, 8'h00, {5'd0, 6'd0, 6'd0}, 0, 0, 16'h0000);
        send_plain(REQ_ADD, 8'hFF, {5'd0, 6'd0, 6'd0}, 0, 0, 16'h1234);
        send_plain(REQ_ADD, 8'h80, {5'd31, 6'd63, 6'd63}, 0, 0, 16'hA5A5);
        send_plain(REQ_PEEK_PRI, 0, 0, 0, 0, 0);
        send_plain(REQ_PEEK_ARR, 0, 0, 0, 0, 0);
        send_plain(REQ_CHG_PRI, 8'hFF, 0, 8'h00, 0, 0);
        send_plain(REQ_CHG_ARR, 0, {5'd0, 6'd0, 6'd0}, 0, {5'd31, 6'd63, 6'd63}, 0);
        send_plain(REQ_CHG_PRI, 8'h77, 0, 8'h01, 0, 0);
        send_plain(REQ_NOP, 8'hFF, {5'd31, 6'd63, 6'd63}, 8'hFF, {5'd31, 6'd63, 6'd63}, 16'hFFFF);
        send_plain(REQ_POP_ARR, 0, 0, 0, 0, 0);
        send_plain(REQ_POP_PRI, 0, 0, 0, 0, 0);
        for (int i = 0; i < 15; i++) send_req(make_req(REQ_ADD));
        send_req(make_req(REQ_ADD));
        send_req(make_req(REQ_ADD));

        // Long receiver hold while requests keep coming; then a full drain.
        drain();
        hold_rx = 1;
        for (int i = 0; i < 8; i++) send_req(make_req(3'($urandom_range(1, 6))));
        drain();

        // Random mix, phases leaning toward filling or emptying.
        for (int i = 0; i < 620; i++) begin
            if (i == 560) quiet = 1;
            if (i % 80 == 0) begin
                used_pri.delete();
                used_arr.delete();
            end
            mode = (i / 80) % 3;
            if ($urandom_range(0, 9) < (mode == 0 ? 5 : (mode == 1 ? 2 : 3)))
                req = REQ_ADD;
            else if ($urandom_range(0, 30) == 0)
                req = REQ_NOP;
            else
                req = 3'($urandom_range(1, 6));
            send_req(make_req(req));
        end
        i_s_tvalid <= 0;
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d requests (adds, pops, peeks, changes, unused code); %0d results checked.",
            sent, board.checked);
        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
